// ----- hw/rtl/cwp_pkg.sv -----
package cwp_pkg;

   localparam int MAX_GRID_COLS = 64;
   localparam int MAX_GRID_ROWS = 64;
   localparam int MAX_MAP_DIM   = 4096;

   localparam logic [1:0] CSR_MAP_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_GRID_STEP     = 2'd2;
   localparam logic [1:0] CSR_WINDOW_RADIUS = 2'd3;

   localparam logic       OP_LOAD  = 1'b0;
   localparam logic       OP_FETCH = 1'b1;

   localparam logic [7:0] OCCUPIED_VALUE = 8'd100;

   typedef struct packed {
      logic        op;
      logic [11:0] pixel_col;
      logic [11:0] pixel_row;
      logic        is_free;
      logic        is_occupied;
   } cmd_type;

endpackage

// ----- hw/rtl/coverage_waypoint_planner.sv -----
// Coverage waypoint planner. Load items (op 0) carry one occupancy pixel; fetch
// items (op 1) return the next free, obstacle-clear grid point in serpentine
// column order, or tour_done and a rewind when none is left. A two-entry queue
// sits between the intake and the execution engine, which works on one item at
// a time. Every item first leaves the queue and goes through a 13-step
// bit-serial division by the grid step (grid counts and pixel indices). A
// load then reads the row of its grid point and writes it back if the pixel
// lies on the grid, and an occupied pixel inside the map then reads and
// writes each grid row in turn, up to 64, for the obstacle marks. A fetch
// reads and then tests each grid position it examines, passes through the
// scan and test states for every move to the next column, and waits while an
// earlier result is still held. The grid stores are read through registers
// and start cleared after reset with no clearing pass: per-row valid bits stand in for the clear.
module coverage_waypoint_planner
   import cwp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_op,
   input  logic [11:0]   req_pixel_col,
   input  logic [11:0]   req_pixel_row,
   input  logic signed [7:0] req_cell_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [5:0]    rsp_goal_col,
   output logic [5:0]    rsp_goal_row,
   output logic          rsp_heading_down,
   output logic          rsp_goal_found,
   output logic          rsp_tour_done,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [12:0]   csr_data
);

   logic [12:0] map_width_ff;
   logic [12:0] map_height_ff;
   logic [7:0]  grid_step_ff;
   logic [4:0]  window_radius_ff;
   logic        q_valid, q_pop;
   cmd_type     q_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff     <= 13'd1280;
         map_height_ff    <= 13'd1280;
         grid_step_ff     <= 8'd20;
         window_radius_ff <= 5'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:     map_width_ff     <= csr_data;
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_data;
            CSR_GRID_STEP:     grid_step_ff     <= csr_data[7:0];
            CSR_WINDOW_RADIUS: window_radius_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   cwp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .req_cell_value (req_cell_value),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd)
   );

   cwp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .map_width        (map_width_ff),
      .map_height       (map_height_ff),
      .grid_step        (grid_step_ff),
      .window_radius    (window_radius_ff),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_cmd            (q_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_goal_col     (rsp_goal_col),
      .rsp_goal_row     (rsp_goal_row),
      .rsp_heading_down (rsp_heading_down),
      .rsp_goal_found   (rsp_goal_found),
      .rsp_tour_done    (rsp_tour_done)
   );

endmodule

// ----- hw/rtl/cwp_front.sv -----
module cwp_front
   import cwp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_op,
   input  logic [11:0]   req_pixel_col,
   input  logic [11:0]   req_pixel_row,
   input  logic [7:0]    req_cell_value,
   output logic          q_valid,
   input  logic          q_pop,
   output cmd_type       q_cmd
);

   cmd_type q_ff [2];
   logic    wr_ptr_ff, wr_ptr_in;
   logic    rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic    push;
   cmd_type cmd;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      cmd.op          = req_op;
      cmd.pixel_col   = req_pixel_col;
      cmd.pixel_row   = req_pixel_row;
      cmd.is_free     = (req_cell_value == 8'd0);
      cmd.is_occupied = (req_cell_value == OCCUPIED_VALUE);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ----- hw/rtl/cwp_back.sv -----
module cwp_back
   import cwp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [12:0]   map_width,
   input  logic [12:0]   map_height,
   input  logic [7:0]    grid_step,
   input  logic [4:0]    window_radius,
   input  logic          q_valid,
   output logic          q_pop,
   input  cmd_type       q_cmd,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [5:0]    rsp_goal_col,
   output logic [5:0]    rsp_goal_row,
   output logic          rsp_heading_down,
   output logic          rsp_goal_found,
   output logic          rsp_tour_done
);

   localparam int CW = $clog2(MAX_GRID_COLS + 1);
   localparam int RW = $clog2(MAX_GRID_ROWS + 1);
   localparam int CI = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
   localparam int RI = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
   localparam int DW = $clog2(MAX_MAP_DIM + 1);
   localparam int PW = DW + 8;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_LOAD  = 4'd3;
   localparam logic [3:0] ST_LWR   = 4'd4;
   localparam logic [3:0] ST_MRD   = 4'd5;
   localparam logic [3:0] ST_MWR   = 4'd6;
   localparam logic [3:0] ST_SCAN  = 4'd7;
   localparam logic [3:0] ST_TEST  = 4'd8;

   logic [3:0] state_ff, state_in;

   logic [MAX_GRID_COLS-1:0] free_ff [MAX_GRID_ROWS];
   logic [MAX_GRID_COLS-1:0] near_ff [MAX_GRID_ROWS];
   logic [MAX_GRID_COLS-1:0] free_rd_ff, near_rd_ff;
   logic [MAX_GRID_ROWS-1:0] rvalid_ff;

   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_k_ff, cur_k_in;

   cmd_type       cmd_ff;
   logic [7:0]    step_ff;
   logic [DW-1:0] wdim_ff, hdim_ff;

   // restoring dividers for grid counts and pixel grid indices
   logic [4:0]    dcnt_ff, dcnt_in;
   logic [DW-1:0] dw_q_ff, dh_q_ff, dc_q_ff, dr_q_ff;
   logic [8:0]    dw_r_ff, dh_r_ff, dc_r_ff, dr_r_ff;
   logic [CW-1:0] gx_ff;
   logic [RW-1:0] gy_ff;
   logic [RW-1:0] mrow_ff;

   logic          rsp_valid_ff;
   logic [5:0]    o_col_ff, o_row_ff;
   logic          o_head_ff, o_found_ff, o_done_ff;

   logic [7:0]    step_eff;
   logic [DW-1:0] wdim_eff, hdim_eff;

   logic          col_ok, k_ok;
   logic [RW-1:0] scan_row;
   logic          hit;
   logic [RI-1:0] row_idx;
   logic [CI-1:0] col_idx;

   logic [PW-1:0] row_pos;
   logic          row_near;
   logic [MAX_GRID_COLS-1:0] col_near;
   logic [PW-1:0] cpos [MAX_GRID_COLS];

   logic          rsp_free;
   logic          scan_end;

   logic [DW+8:0] dw_s, dh_s, dc_s, dr_s;
   logic          pix_in;
   logic          on_grid;

   logic [RI-1:0] ld_row, mk_row;
   logic          ld_rv, mk_rv;
   logic          ld_write, mk_write;
   logic [MAX_GRID_COLS-1:0] ld_free;
   logic          free_rd_en, near_rd_en;
   logic [RI-1:0] free_raddr, near_raddr;
   logic          free_we, near_we;
   logic [RI-1:0] free_waddr, near_waddr;
   logic [MAX_GRID_COLS-1:0] free_wdata, near_wdata;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_goal_col     = o_col_ff;
   assign rsp_goal_row     = o_row_ff;
   assign rsp_heading_down = o_head_ff;
   assign rsp_goal_found   = o_found_ff;
   assign rsp_tour_done    = o_done_ff;

   always_comb begin
      step_eff = (grid_step == 8'd0) ? 8'd1 : grid_step;
      wdim_eff = (map_width  > 13'(MAX_MAP_DIM)) ? DW'(MAX_MAP_DIM) : DW'(map_width);
      hdim_eff = (map_height > 13'(MAX_MAP_DIM)) ? DW'(MAX_MAP_DIM) : DW'(map_height);
   end

   function automatic logic [8+DW:0] div_step(input logic [8:0] r, input logic [DW-1:0] q,
                                              input logic [7:0] d);
      logic [9:0] t;
      logic       ge;
      t  = {r, q[DW-1]};
      ge = (t >= {2'b00, d});
      t  = ge ? t - {2'b00, d} : t;
      return {t[8:0], q[DW-2:0], ge};
   endfunction

   always_comb begin
      col_ok   = cur_col_ff < gx_ff;
      k_ok     = cur_k_ff < gy_ff;
      scan_row = cur_col_ff[0] ? (gy_ff - RW'(1) - cur_k_ff) : cur_k_ff;
      row_idx  = scan_row[RI-1:0];
      col_idx  = cur_col_ff[CI-1:0];
      hit      = col_ok && k_ok && rvalid_ff[row_idx] && free_rd_ff[col_idx]
                 && !near_rd_ff[col_idx];
   end

   always_comb begin
      row_pos  = PW'(mrow_ff) * PW'(step_ff);
      row_near = (row_pos >= PW'(cmd_ff.pixel_row))
                 ? (row_pos - PW'(cmd_ff.pixel_row) <= PW'(window_radius))
                 : (PW'(cmd_ff.pixel_row) - row_pos <= PW'(window_radius));
      for (int i = 0; i < MAX_GRID_COLS; i++) begin
         cpos[i]     = PW'(i) * PW'(step_ff);
         col_near[i] = (CW'(i) < gx_ff) &&
                       ((cpos[i] >= PW'(cmd_ff.pixel_col))
                        ? (cpos[i] - PW'(cmd_ff.pixel_col) <= PW'(window_radius))
                        : (PW'(cmd_ff.pixel_col) - cpos[i] <= PW'(window_radius)));
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign scan_end = (state_ff == ST_TEST) && rsp_free && (!col_ok || hit);

   always_comb begin
      state_in   = state_ff;
      cur_col_in = cur_col_ff;
      cur_k_in   = cur_k_ff;
      dcnt_in    = dcnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            dcnt_in  = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'(DW - 1)) begin
               state_in = (cmd_ff.op == OP_FETCH) ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_LWR;
         end
         ST_LWR: begin
            state_in = (cmd_ff.is_occupied && pix_in && gy_ff != '0) ? ST_MRD : ST_IDLE;
         end
         ST_MRD: begin
            state_in = ST_MWR;
         end
         ST_MWR: begin
            state_in = (mrow_ff + RW'(1) >= gy_ff) ? ST_IDLE : ST_MRD;
         end
         ST_SCAN: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (rsp_free) begin
               if (!col_ok || hit) begin
                  state_in = ST_IDLE;
                  if (hit) begin
                     cur_k_in = cur_k_ff + RW'(1);
                  end else begin
                     cur_col_in = '0;
                     cur_k_in   = '0;
                  end
               end else if (!k_ok) begin
                  state_in   = ST_SCAN;
                  cur_col_in = cur_col_ff + CW'(1);
                  cur_k_in   = '0;
               end else begin
                  state_in = ST_SCAN;
                  cur_k_in = cur_k_ff + RW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dw_s    = div_step(dw_r_ff, dw_q_ff, step_ff);
      dh_s    = div_step(dh_r_ff, dh_q_ff, step_ff);
      dc_s    = div_step(dc_r_ff, dc_q_ff, step_ff);
      dr_s    = div_step(dr_r_ff, dr_q_ff, step_ff);
      pix_in  = (DW'(cmd_ff.pixel_col) < wdim_ff) && (DW'(cmd_ff.pixel_row) < hdim_ff);
      on_grid = (dc_r_ff == 9'd0) && (dr_r_ff == 9'd0) &&
                (dc_q_ff < DW'(gx_ff)) && (dr_q_ff < DW'(gy_ff));
   end

   always_comb begin
      ld_row     = dr_q_ff[RI-1:0];
      mk_row     = mrow_ff[RI-1:0];
      ld_rv      = rvalid_ff[ld_row];
      mk_rv      = rvalid_ff[mk_row];
      ld_write   = (state_ff == ST_LWR) && pix_in && on_grid;
      mk_write   = (state_ff == ST_MWR) && row_near;
      ld_free    = ld_rv ? free_rd_ff : '0;
      ld_free[dc_q_ff[CI-1:0]] = cmd_ff.is_free;
      free_rd_en = (state_ff == ST_LOAD) || (state_ff == ST_SCAN);
      free_raddr = (state_ff == ST_LOAD) ? ld_row : row_idx;
      near_rd_en = (state_ff == ST_MRD) || (state_ff == ST_SCAN);
      near_raddr = (state_ff == ST_MRD) ? mk_row : row_idx;
      free_we    = ld_write || (mk_write && !mk_rv);
      free_waddr = ld_write ? ld_row : mk_row;
      free_wdata = ld_write ? ld_free : '0;
      near_we    = (ld_write && !ld_rv) || mk_write;
      near_waddr = ld_write ? ld_row : mk_row;
      near_wdata = ld_write ? '0 : (mk_rv ? (near_rd_ff | col_near) : col_near);
   end

   always_ff @(posedge clock) begin
      if (free_rd_en) begin
         free_rd_ff <= free_ff[free_raddr];
      end
      if (near_rd_en) begin
         near_rd_ff <= near_ff[near_raddr];
      end
      if (free_we) begin
         free_ff[free_waddr] <= free_wdata;
      end
      if (near_we) begin
         near_ff[near_waddr] <= near_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_col_ff   <= '0;
         cur_k_ff     <= '0;
         rvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_col_ff <= cur_col_in;
         cur_k_ff   <= cur_k_in;
         if (scan_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ld_write || mk_write) begin
            rvalid_ff[near_waddr] <= 1'b1;
         end
      end
      dcnt_ff <= dcnt_in;
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      if (state_ff == ST_SETUP) begin
         step_ff <= step_eff;
         wdim_ff <= wdim_eff;
         hdim_ff <= hdim_eff;
         dw_q_ff <= wdim_eff;
         dh_q_ff <= hdim_eff;
         dc_q_ff <= DW'(cmd_ff.pixel_col);
         dr_q_ff <= DW'(cmd_ff.pixel_row);
         dw_r_ff <= '0;
         dh_r_ff <= '0;
         dc_r_ff <= '0;
         dr_r_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         {dw_r_ff, dw_q_ff} <= dw_s;
         {dh_r_ff, dh_q_ff} <= dh_s;
         {dc_r_ff, dc_q_ff} <= dc_s;
         {dr_r_ff, dr_q_ff} <= dr_s;
      end
      if (state_ff == ST_DIV && dcnt_ff == 5'(DW - 1)) begin
         gx_ff <= CW'((dw_s[DW-1:0] > DW'(MAX_GRID_COLS)) ? DW'(MAX_GRID_COLS)
                                                          : dw_s[DW-1:0]);
         gy_ff <= RW'((dh_s[DW-1:0] > DW'(MAX_GRID_ROWS)) ? DW'(MAX_GRID_ROWS)
                                                          : dh_s[DW-1:0]);
      end
      if (state_ff == ST_LWR) begin
         mrow_ff <= '0;
      end
      if (state_ff == ST_MWR) begin
         mrow_ff <= mrow_ff + RW'(1);
      end
      if (scan_end) begin
         o_col_ff   <= hit ? 6'(cur_col_ff) : 6'd0;
         o_row_ff   <= hit ? 6'(scan_row) : 6'd0;
         o_head_ff  <= hit ? cur_col_ff[0] : 1'b0;
         o_found_ff <= hit;
         o_done_ff  <= !hit;
      end
   end

endmodule
